// File: rtl/mqm_pkg.sv
// Shared constants and helpers for the mDNS query matcher.
// Depends on nothing; imported by mdns_query_matcher.
package mqm_pkg;

    // Verdict codes carried on the result channel.
    localparam logic [1:0] VERDICT_SHORT    = 2'd0;
    localparam logic [1:0] VERDICT_RESPONSE = 2'd1;
    localparam logic [1:0] VERDICT_NO_MATCH = 2'd2;
    localparam logic [1:0] VERDICT_RESPOND  = 2'd3;

    // DNS header and question constants.
    localparam int          HEADER_BYTES = 12;
    localparam logic [15:0] QTYPE_PTR    = 16'd12;
    localparam logic [15:0] QTYPE_ANY    = 16'd255;

    // Service name; the short form is the first SHORT_LEN characters.
    localparam int FULL_LEN  = 19;
    localparam int SHORT_LEN = 13;
    localparam int NAME_CAP  = 20;
    localparam logic [8*FULL_LEN-1:0] SERVICE_NAME = "_oscjson._tcp.local";

    // Character of the service name at a given position (position below FULL_LEN).
    function automatic logic [7:0] service_char(input logic [4:0] pos);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < FULL_LEN; k++) begin
            if (5'(k) == pos) begin
                c = SERVICE_NAME[8*(FULL_LEN-1-k) +: 8];
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/mqm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mdns_query_matcher.sv
// Top level of the mDNS query matcher: packet buffer and question walk sequencer.
// Depends on mqm_pkg and mqm_ram.
//
// Usage. Packet bytes enter on the s_ channel (s_packet_byte, s_is_last), one
// item per cycle while the block is receiving. The first BUFFER_BYTES bytes of
// a packet are kept in the packet RAM; later bytes are accepted and dropped.
// After the item marked last, the block stops taking items and walks the DNS
// questions out of the RAM. It then gives one verdict item on the m_ channel:
// 0 too short, 1 response, 2 no matching question, 3 should respond.
// Path from the last byte to the verdict: a packet under 12 bytes goes straight
// to the verdict, a response ends after the flags byte, else the header is read
// and, per question walked, each label, name character and pointer and the
// closing zero byte, then the type field. Each RAM byte is issued in one state and
// used in the next, as the single read port has a registered read.
// The verdict sits in an output register; a new packet is accepted while it
// waits. If the next verdict is ready before the old one is taken, the block
// holds it and accepts no items until the output register frees up.
// Reset (aresetn low, synchronous) returns the block to receiving with an
// empty buffer and no verdict pending. RAM contents are not cleared.
module mdns_query_matcher #(
    parameter int BUFFER_BYTES = 4096,
    parameter int MAX_JUMPS    = 10
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_packet_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict
);

    import mqm_pkg::*;

    localparam int AW     = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = AW + 1;
    localparam int POS_W  = (CNT_W > 14) ? CNT_W : 14;
    localparam int JMP_W  = $clog2(MAX_JUMPS + 1);

    typedef enum logic [13:0] {
        ST_RECV     = 14'b00000000000001,
        ST_FLAGS_RD = 14'b00000000000010,
        ST_FLAGS    = 14'b00000000000100,
        ST_QD_HI    = 14'b00000000001000,
        ST_QD_LO    = 14'b00000000010000,
        ST_Q_TOP    = 14'b00000000100000,
        ST_LAB_RD   = 14'b00000001000000,
        ST_LAB      = 14'b00000010000000,
        ST_PTR      = 14'b00000100000000,
        ST_CHR_RD   = 14'b00001000000000,
        ST_CHR      = 14'b00010000000000,
        ST_NAME_END = 14'b00100000000000,
        ST_TYPE     = 14'b01000000000000,
        ST_FIN      = 14'b10000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [POS_W-1:0]  qo_reg, qo_next;
    logic [POS_W-1:0]  rp_reg, rp_next;
    logic [JMP_W-1:0]  jumps_reg, jumps_next;
    logic [15:0]       qdone_reg, qdone_next;
    logic [15:0]       qdcount_reg, qdcount_next;
    logic [4:0]        idx_reg, idx_next;
    logic              name_ok_reg, name_ok_next;
    logic              match_reg, match_next;
    logic              jumped_reg, jumped_next;
    logic              type_lo_reg, type_lo_next;
    logic [7:0]        lab_reg, lab_next;
    logic [7:0]        hi_reg, hi_next;
    logic [1:0]        pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_verdict_reg, m_verdict_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [POS_W-1:0]  rd_pos;
    logic [7:0]        rd_data;

    logic              put_en;
    logic [7:0]        put_byte;
    logic [POS_W-1:0]  len_pos;
    logic [POS_W-1:0]  qo_eff;
    logic [CNT_W-1:0]  count_after;
    logic              name_hit;
    logic [15:0]       qtype;

    // Packet buffer.
    mqm_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_packet_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_packet_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_pos[AW-1:0]),
        .rd_data (rd_data)
    );

    assign len_pos  = POS_W'(byte_count_reg);
    assign qo_eff   = jumped_reg ? qo_reg : rp_reg;
    assign name_hit = name_ok_reg && ((idx_reg == 5'(FULL_LEN)) || (idx_reg == 5'(SHORT_LEN)));
    assign qtype    = {hi_reg, rd_data};
    assign wr_addr  = byte_count_reg[AW-1:0];
    assign s_ready  = (state_reg == ST_RECV);
    assign m_valid  = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    // Sequencer: receive, header checks, name decode and question walk.
    always_comb begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        qo_next         = qo_reg;
        rp_next         = rp_reg;
        jumps_next      = jumps_reg;
        qdone_next      = qdone_reg;
        qdcount_next    = qdcount_reg;
        idx_next        = idx_reg;
        name_ok_next    = name_ok_reg;
        match_next      = match_reg;
        jumped_next     = jumped_reg;
        type_lo_next    = type_lo_reg;
        lab_next        = lab_reg;
        hi_next         = hi_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_verdict_next  = m_verdict_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_pos          = rp_reg;
        put_en          = 1'b0;
        put_byte        = 8'h00;
        count_after     = byte_count_reg;

        unique case (state_reg)
            ST_RECV: begin
                if (s_valid) begin
                    if (byte_count_reg < CNT_W'(BUFFER_BYTES)) begin
                        wr_en       = 1'b1;
                        count_after = byte_count_reg + CNT_W'(1);
                    end
                    byte_count_next = count_after;
                    if (s_is_last) begin
                        if (count_after < CNT_W'(HEADER_BYTES)) begin
                            pend_next  = VERDICT_SHORT;
                            state_next = ST_FIN;
                        end else begin
                            state_next = ST_FLAGS_RD;
                        end
                    end
                end
            end
            ST_FLAGS_RD: begin
                rd_en      = 1'b1;
                rd_pos     = POS_W'(2);
                state_next = ST_FLAGS;
            end
            ST_FLAGS: begin
                if (rd_data[7]) begin
                    pend_next  = VERDICT_RESPONSE;
                    state_next = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_pos     = POS_W'(4);
                    state_next = ST_QD_HI;
                end
            end
            ST_QD_HI: begin
                hi_next    = rd_data;
                rd_en      = 1'b1;
                rd_pos     = POS_W'(5);
                state_next = ST_QD_LO;
            end
            ST_QD_LO: begin
                qdcount_next = {hi_reg, rd_data};
                qo_next      = POS_W'(HEADER_BYTES);
                qdone_next   = 16'd0;
                match_next   = 1'b0;
                state_next   = ST_Q_TOP;
            end
            ST_Q_TOP: begin
                // Start the next question or finish the walk.
                if ((qdone_reg < qdcount_reg) && (qo_reg < len_pos)) begin
                    rp_next      = qo_reg;
                    jumps_next   = '0;
                    idx_next     = 5'd0;
                    name_ok_next = 1'b1;
                    jumped_next  = 1'b0;
                    state_next   = ST_LAB_RD;
                end else begin
                    pend_next  = match_reg ? VERDICT_RESPOND : VERDICT_NO_MATCH;
                    state_next = ST_FIN;
                end
            end
            ST_LAB_RD: begin
                if (rp_reg < len_pos) begin
                    rd_en      = 1'b1;
                    state_next = ST_LAB;
                end else begin
                    state_next = ST_NAME_END;
                end
            end
            ST_LAB: begin
                lab_next = rd_data;
                if (rd_data[7:6] == 2'b11) begin
                    // Compression pointer: fetch the low byte of the target.
                    if (({1'b0, rp_reg} + (POS_W+1)'(1)) >= {1'b0, len_pos}) begin
                        state_next = ST_NAME_END;
                    end else begin
                        rd_en      = 1'b1;
                        rd_pos     = rp_reg + POS_W'(1);
                        state_next = ST_PTR;
                    end
                end else begin
                    rp_next = rp_reg + POS_W'(1);
                    if (rd_data == 8'h00) begin
                        state_next = ST_NAME_END;
                    end else begin
                        put_en     = (idx_reg != 5'd0);
                        put_byte   = ".";
                        state_next = ST_CHR_RD;
                    end
                end
            end
            ST_PTR: begin
                if (!jumped_reg) begin
                    qo_next = rp_reg + POS_W'(2);
                end
                jumped_next = 1'b1;
                rp_next     = POS_W'({lab_reg[5:0], rd_data});
                if (jumps_reg == JMP_W'(MAX_JUMPS)) begin
                    state_next = ST_NAME_END;
                end else begin
                    jumps_next = jumps_reg + JMP_W'(1);
                    state_next = ST_LAB_RD;
                end
            end
            ST_CHR_RD: begin
                if ((lab_reg != 8'h00) && (rp_reg < len_pos)) begin
                    rd_en      = 1'b1;
                    rp_next    = rp_reg + POS_W'(1);
                    lab_next   = lab_reg - 8'd1;
                    state_next = ST_CHR;
                end else begin
                    state_next = ST_LAB_RD;
                end
            end
            ST_CHR: begin
                put_en     = 1'b1;
                put_byte   = rd_data;
                state_next = ST_CHR_RD;
            end
            ST_NAME_END: begin
                // The type and class fields must fit in the stored bytes.
                qo_next = qo_eff;
                if (({1'b0, qo_eff} + (POS_W+1)'(4)) > {1'b0, len_pos}) begin
                    pend_next  = match_reg ? VERDICT_RESPOND : VERDICT_NO_MATCH;
                    state_next = ST_FIN;
                end else begin
                    rd_en        = 1'b1;
                    rd_pos       = qo_eff;
                    type_lo_next = 1'b0;
                    state_next   = ST_TYPE;
                end
            end
            ST_TYPE: begin
                if (!type_lo_reg) begin
                    hi_next      = rd_data;
                    rd_en        = 1'b1;
                    rd_pos       = qo_reg + POS_W'(1);
                    type_lo_next = 1'b1;
                end else begin
                    qo_next    = qo_reg + POS_W'(4);
                    qdone_next = qdone_reg + 16'd1;
                    if (name_hit && ((qtype == QTYPE_PTR) || (qtype == QTYPE_ANY))) begin
                        match_next = 1'b1;
                    end
                    state_next = ST_Q_TOP;
                end
            end
            ST_FIN: begin
                // Load the output register once it is free and rearm for a packet.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_verdict_next  = pend_reg;
                    byte_count_next = '0;
                    qo_next         = '0;
                    rp_next         = '0;
                    jumps_next      = '0;
                    qdone_next      = 16'd0;
                    idx_next        = 5'd0;
                    match_next      = 1'b0;
                    state_next      = ST_RECV;
                end
            end
            default: begin
                state_next = ST_RECV;
            end
        endcase

        // Append one character to the decoded name and compare it on the fly.
        if (put_en && (idx_reg < 5'(NAME_CAP))) begin
            if (idx_reg < 5'(FULL_LEN)) begin
                name_ok_next = name_ok_reg && (put_byte == service_char(idx_reg));
            end
            idx_next = idx_reg + 5'd1;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RECV;
            byte_count_reg <= '0;
            qo_reg         <= '0;
            rp_reg         <= '0;
            jumps_reg      <= '0;
            qdone_reg      <= 16'd0;
            idx_reg        <= 5'd0;
            match_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            qo_reg         <= qo_next;
            rp_reg         <= rp_next;
            jumps_reg      <= jumps_next;
            qdone_reg      <= qdone_next;
            idx_reg        <= idx_next;
            match_reg      <= match_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        qdcount_reg   <= qdcount_next;
        name_ok_reg   <= name_ok_next;
        jumped_reg    <= jumped_next;
        type_lo_reg   <= type_lo_next;
        lab_reg       <= lab_next;
        hi_reg        <= hi_next;
        pend_reg      <= pend_next;
        m_verdict_reg <= m_verdict_next;
    end

endmodule

// File: tb/mdns_query_matcher_tb.sv
// Self-checking testbench for mdns_query_matcher: sends DNS packets byte by byte
// and checks each verdict against a packet-level predictor kept in this file.
// Depends on mqm_pkg for the verdict and query type codes.
module mdns_query_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mqm_pkg::*;

    localparam int BUFFER_BYTES = 4096;
    localparam int MAX_JUMPS    = 10;
    localparam int NAME_LIMIT   = 20;
    localparam int SHORT_CHARS  = 13;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 200;
    localparam int RANDOM_PKTS  = 4;

    localparam logic [15:0] FLAG_RESPONSE = 16'h8000;
    localparam logic [15:0] QTYPE_A       = 16'd1;
    localparam logic [15:0] QTYPE_AAAA    = 16'd28;
    localparam logic [15:0] QTYPE_SRV     = 16'd33;
    localparam logic [15:0] CLASS_IN      = 16'd1;
    localparam logic [7:0]  POINTER_TAG   = 8'hC0;

    localparam string FULL_SERVICE = "_oscjson._tcp.local";

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_packet_byte = 8'h00;
    logic       s_is_last     = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [1:0] m_verdict;

    // Packet bytes stored so far and the state of the question walk.
    logic [7:0] rx_bytes [BUFFER_BYTES];
    int         rx_count;
    logic [7:0] name_chars [NAME_LIMIT];
    int         name_len;
    int         q_offset;

    logic [1:0] pending_verdicts [$];
    logic [7:0] frame [$];
    int         name_offsets [$];
    int         verdict_tally [4];
    int         items_sent;
    int         packets_sent;
    int         mismatch_count;
    int         idle_cycles;
    bit         tx_gaps_on    = 1'b1;
    bit         rx_gaps_on    = 1'b1;
    int         hold_requests = 0;

    mdns_query_matcher #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_JUMPS   (MAX_JUMPS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_packet_byte(s_packet_byte),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Verdict predictor
    // ---------------------------------------------------------------

    // Adds one character to the decoded name; the length saturates at the limit.
    function automatic void append_name_char(input logic [7:0] c);
        if (name_len < NAME_LIMIT) begin
            name_chars[name_len] = c;
            name_len++;
        end
    endfunction

    // Decodes the name at q_offset, following compression pointers, and moves
    // q_offset past the name as it sits in the question.
    function automatic void walk_name();
        int         pos;
        int         hops;
        int         k;
        bit         jumped;
        logic [7:0] lab;
        pos    = q_offset;
        hops   = 0;
        jumped = 1'b0;
        name_len = 0;
        while (pos < rx_count) begin
            lab = rx_bytes[pos];
            if (lab[7:6] == 2'b11) begin
                // A pointer needs its second byte inside the data.
                if (pos + 1 >= rx_count) break;
                if (!jumped) q_offset = pos + 2;
                jumped = 1'b1;
                pos = {lab[5:0], rx_bytes[pos + 1]};
                hops++;
                if (hops > MAX_JUMPS) break;
                continue;
            end
            pos++;
            if (lab == 8'h00) break;
            if (name_len > 0) append_name_char(".");
            for (k = 0; k < int'(lab) && pos < rx_count; k++) begin
                append_name_char(rx_bytes[pos]);
                pos++;
            end
        end
        if (!jumped) q_offset = pos;
    endfunction

    // The name matches when it equals the full service name or its short form.
    function automatic bit name_is_service();
        int k;
        if (name_len != FULL_SERVICE.len() && name_len != SHORT_CHARS) return 1'b0;
        for (k = 0; k < name_len; k++) begin
            if (name_chars[k] != FULL_SERVICE[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] predict_verdict();
        int qd;
        int done;
        int qtype;
        bit hit;
        if (rx_count < 12) return VERDICT_SHORT;
        if (rx_bytes[2][7]) return VERDICT_RESPONSE;
        qd = {rx_bytes[4], rx_bytes[5]};
        q_offset = 12;
        hit = 1'b0;
        for (done = 0; done < qd && q_offset < rx_count; done++) begin
            walk_name();
            if (q_offset + 4 > rx_count) break;
            qtype = {rx_bytes[q_offset], rx_bytes[q_offset + 1]};
            q_offset += 4;
            if (name_is_service() && (qtype == QTYPE_PTR || qtype == QTYPE_ANY)) hit = 1'b1;
        end
        return hit ? VERDICT_RESPOND : VERDICT_NO_MATCH;
    endfunction

    // ---------------------------------------------------------------
    // Sender, receiver, checker and watchdog
    // ---------------------------------------------------------------

    // Offers one item and waits for its acceptance; the last byte of a packet
    // queues the predicted verdict.
    task automatic send_byte(input logic [7:0] b, input bit is_final);
        int         gap;
        logic [1:0] predicted;
        gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_packet_byte <= b;
        s_is_last     <= is_final;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (rx_count < BUFFER_BYTES) begin
            rx_bytes[rx_count] = b;
            rx_count++;
        end
        if (is_final) begin
            predicted = predict_verdict();
            pending_verdicts.insert(pending_verdicts.size(), predicted);
            verdict_tally[predicted]++;
            packets_sent++;
            rx_count = 0;
        end
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame.size(); k++) send_byte(frame[k], k == frame.size() - 1);
        frame.delete();
    endtask

    // Lets the input go idle until every verdict has come back.
    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        while (pending_verdicts.size() > 0) @(posedge aclk);
    endtask

    // Receiver: a random wait before each verdict, or one long hold on request.
    initial begin : output_side
        int gap;
        int holds_served;
        holds_served = 0;
        forever begin
            gap = rx_gaps_on ? $urandom_range(0, 4) : 0;
            if (hold_requests > holds_served) begin
                gap = LONG_HOLD;
                holds_served++;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Each accepted verdict is compared with the oldest prediction.
    always @(posedge aclk) begin : verdict_check
        logic [1:0] expected_verdict;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %0d with no packet outstanding", m_verdict));
            end else begin
                expected_verdict = pending_verdicts.pop_front();
                if (m_verdict !== expected_verdict) begin
                    report_mismatch($sformatf("verdict %0d, predicted %0d",
                                              m_verdict, expected_verdict));
                end
            end
        end
    end

    // The run ends if neither channel moves an item for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Packet building
    // ---------------------------------------------------------------

    // Appends one byte to the packet under construction.
    function automatic void frame_add(input logic [7:0] b);
        frame.insert(frame.size(), b);
    endfunction

    function automatic void add_header(input logic [15:0] flags, input logic [15:0] qd);
        int k;
        frame_add(8'($urandom));
        frame_add(8'($urandom));
        frame_add(flags[15:8]);
        frame_add(flags[7:0]);
        frame_add(qd[15:8]);
        frame_add(qd[7:0]);
        for (k = 0; k < 6; k++) frame_add(8'($urandom));
    endfunction

    // Writes a dotted name as length-prefixed labels with a closing zero.
    function automatic void add_label_name(input string s);
        int start;
        int k;
        int i;
        start = 0;
        for (k = 0; k <= s.len(); k++) begin
            if (k == s.len() || s[k] == ".") begin
                frame_add(8'(k - start));
                for (i = start; i < k; i++) frame_add(s[i]);
                start = k + 1;
            end
        end
        frame_add(8'h00);
    endfunction

    function automatic void add_pointer(input int target);
        logic [13:0] t;
        t = 14'(target);
        frame_add(POINTER_TAG | {2'b00, t[13:8]});
        frame_add(t[7:0]);
    endfunction

    function automatic void add_qtail(input logic [15:0] qtype, input logic [15:0] qclass);
        frame_add(qtype[15:8]);
        frame_add(qtype[7:0]);
        frame_add(qclass[15:8]);
        frame_add(qclass[7:0]);
    endfunction

    function automatic void add_random_bytes(input int count);
        int k;
        for (k = 0; k < count; k++) frame_add(8'($urandom));
    endfunction

    function automatic void add_random_name();
        int labels;
        int k;
        int n;
        labels = $urandom_range(1, 3);
        for (k = 0; k < labels; k++) begin
            n = $urandom_range(1, 12);
            frame_add(8'(n));
            add_random_bytes(n);
        end
        frame_add(8'h00);
    endfunction

    // The service name with one character replaced by a random nonzero byte.
    function automatic void add_near_miss();
        string s;
        s = FULL_SERVICE;
        s[$urandom_range(0, s.len() - 1)] = byte'($urandom_range(1, 255));
        add_label_name(s);
    endfunction

    function automatic logic [15:0] random_qtype();
        case ($urandom_range(0, 5))
            0: return QTYPE_PTR;
            1: return QTYPE_ANY;
            2: return QTYPE_A;
            3: return QTYPE_AAAA;
            4: return QTYPE_SRV;
            default: return 16'($urandom);
        endcase
    endfunction

    // A query (now and then a response or with a random question count) with a few
    // questions drawn from service names, near misses, random names and compression pointers.
    function automatic void build_random_query();
        int          qd;
        int          k;
        int          start;
        logic [15:0] flags;
        qd = $urandom_range(1, 3);
        flags = 16'($urandom);
        flags[15] = ($urandom_range(0, 7) == 0);
        add_header(flags, ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(qd));
        name_offsets.delete();
        for (k = 0; k < qd; k++) begin
            start = frame.size();
            case ($urandom_range(0, 6))
                0, 1: add_label_name(FULL_SERVICE);
                2: add_label_name(FULL_SERVICE.substr(0, SHORT_CHARS - 1));
                3: add_random_name();
                4: begin
                    if (name_offsets.size() > 0) begin
                        add_pointer(name_offsets[$urandom_range(0, name_offsets.size() - 1)]);
                    end else begin
                        add_label_name(FULL_SERVICE);
                    end
                end
                5: add_near_miss();
                default: add_pointer($urandom_range(0, 16383));
            endcase
            name_offsets.insert(name_offsets.size(), start);
            add_qtail(random_qtype(), 16'($urandom));
        end
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_short_packets();
        frame_add(8'($urandom));
        send_frame();
        add_random_bytes(11);
        send_frame();
        // A bare header asks a question but holds none.
        add_header(16'h0000, 16'd1);
        send_frame();
        wait_for_verdicts();
    endtask

    task automatic test_responses();
        add_header(FLAG_RESPONSE | 16'h0400, 16'd1);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // Every flag except the response bit.
        add_header(~FLAG_RESPONSE, 16'd1);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        wait_for_verdicts();
    endtask

    task automatic test_service_match();
        add_header(16'h0000, 16'd1);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        add_header(16'h0000, 16'd1);
        add_label_name(FULL_SERVICE.substr(0, SHORT_CHARS - 1));
        add_qtail(QTYPE_ANY, 16'hFFFF);
        send_frame();
        add_header(16'h0000, 16'd1);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_A, CLASS_IN);
        send_frame();
        add_header(16'h0000, 16'd1);
        add_label_name("_OSCJSON._tcp.local");
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // A question count of zero skips a question that would match.
        add_header(16'h0000, 16'd0);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // The match sits in the third question; the largest count runs to the end.
        add_header(16'h0000, 16'hFFFF);
        add_label_name("host.local");
        add_qtail(QTYPE_A, CLASS_IN);
        add_label_name("_other._udp.local");
        add_qtail(QTYPE_PTR, CLASS_IN);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_ANY, CLASS_IN);
        send_frame();
        wait_for_verdicts();
    endtask

    // Chain of pointers in front of the service name: one from the second
    // question plus (hops - 1) more at the end of the packet.
    task automatic send_pointer_chain(input int hops);
        int k;
        add_header(16'h0000, 16'd2);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_A, CLASS_IN);
        add_pointer(43);
        add_qtail(QTYPE_PTR, CLASS_IN);
        for (k = 0; k < hops - 1; k++) add_pointer((k == hops - 2) ? 12 : 45 + 2 * k);
        send_frame();
    endtask

    task automatic test_compression();
        // Second question reuses the whole first name.
        add_header(16'h0000, 16'd2);
        add_label_name(FULL_SERVICE);
        add_qtail(QTYPE_A, CLASS_IN);
        add_pointer(12);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // Second question reuses only the tail of the first name.
        add_header(16'h0000, 16'd2);
        add_label_name("x._tcp.local");
        add_qtail(QTYPE_A, CLASS_IN);
        add_label_name("_oscjson");
        frame.delete(frame.size() - 1);
        add_pointer(14);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // Exactly the jump limit still decodes; one more ends the name.
        send_pointer_chain(MAX_JUMPS);
        send_pointer_chain(MAX_JUMPS + 1);
        wait_for_verdicts();
    endtask

    task automatic test_broken_names();
        // A pointer that points at itself.
        add_header(16'h0000, 16'd1);
        add_pointer(12);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // A pointer beyond the stored data.
        add_header(16'h0000, 16'd1);
        add_pointer(16383);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // The first pointer byte is the last byte of the packet.
        add_header(16'h0000, 16'd1);
        frame_add(POINTER_TAG);
        send_frame();
        // A label running past the end of the data.
        add_header(16'h0000, 16'd1);
        frame_add(8'h3F);
        add_random_bytes(5);
        send_frame();
        // Length bytes between the label and pointer forms are label lengths.
        add_header(16'h0000, 16'd1);
        frame_add(8'h41);
        add_random_bytes(65);
        frame_add(8'h00);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        add_header(16'h0000, 16'd1);
        frame_add(8'hBF);
        add_random_bytes(20);
        send_frame();
        wait_for_verdicts();
    endtask

    task automatic test_name_oddities();
        int k;
        // Matching name but only three bytes after it.
        add_header(16'h0000, 16'd1);
        add_label_name(FULL_SERVICE);
        frame_add(8'h00);
        frame_add(QTYPE_PTR[7:0]);
        frame_add(8'h00);
        send_frame();
        // Names one character too long and far too long.
        add_header(16'h0000, 16'd2);
        add_label_name("_oscjson._tcp.localx");
        add_qtail(QTYPE_PTR, CLASS_IN);
        add_label_name("_oscjson._tcp.local.extra.labels");
        add_qtail(QTYPE_ANY, CLASS_IN);
        send_frame();
        // A dot inside one label reads the same as the short service name.
        add_header(16'h0000, 16'd1);
        frame_add(8'(SHORT_CHARS));
        for (k = 0; k < SHORT_CHARS; k++) frame_add(FULL_SERVICE[k]);
        frame_add(8'h00);
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        // A zero byte inside a label.
        add_header(16'h0000, 16'd1);
        add_label_name(FULL_SERVICE);
        frame[16] = 8'h00;
        add_qtail(QTYPE_PTR, CLASS_IN);
        send_frame();
        wait_for_verdicts();
    endtask

    // The receiver holds off while packets keep coming, so the block must
    // keep a verdict waiting and stall its input.
    task automatic test_output_stall();
        int k;
        tx_gaps_on = 1'b0;
        hold_requests++;
        for (k = 0; k < 4; k++) begin
            add_header(16'h0000, 16'd1);
            if (k[0]) add_label_name(FULL_SERVICE);
            else add_random_name();
            add_qtail(QTYPE_PTR, CLASS_IN);
            send_frame();
        end
        tx_gaps_on = 1'b1;
        wait_for_verdicts();
    endtask

    task automatic test_random_packets();
        int first_item;
        int first_packet;
        int cut;
        first_item   = items_sent;
        first_packet = packets_sent;
        while (items_sent - first_item < RANDOM_BYTES ||
               packets_sent - first_packet < RANDOM_PKTS) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                // Noise: random bytes of random length.
                0: add_random_bytes($urandom_range(1, 40));
                // Broken: a query cut off at a random point.
                1: begin
                    build_random_query();
                    cut = $urandom_range(1, frame.size());
                    while (frame.size() > cut) frame.delete(frame.size() - 1);
                end
                default: build_random_query();
            endcase
            send_frame();
        end
        rx_gaps_on = 1'b1;
        wait_for_verdicts();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_packets();
        test_responses();
        test_service_match();
        test_compression();
        test_broken_names();
        test_name_oddities();
        test_output_stall();
        test_random_packets();
        repeat (20) @(posedge aclk);
        $display("Sent %0d packets in %0d bytes: short, response, compressed, broken and random.",
                 packets_sent, items_sent);
        $display("Verdicts: short %0d, response %0d, no match %0d, respond %0d; %0d mismatches.",
                 verdict_tally[VERDICT_SHORT], verdict_tally[VERDICT_RESPONSE],
                 verdict_tally[VERDICT_NO_MATCH], verdict_tally[VERDICT_RESPOND],
                 mismatch_count);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: mdns_query_matcher.f
rtl/mqm_pkg.sv
rtl/mqm_ram.sv
rtl/mdns_query_matcher.sv
tb/mdns_query_matcher_tb.sv
